FILE: hw/rtl/bia_pkg.sv
// Shared constants, codes and controller/datapath interface types of the id allocator.
package bia_pkg;

	// Map geometry: one bit per id, stored as 64-bit memory words.
	localparam int ID_COUNT  = 4096;
	localparam int WORD_W    = 64;
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int MAP_WORDS = (ID_COUNT + WORD_W - 1) / WORD_W;
	localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	// Field and register widths.
	localparam int ID_W      = 16;
	localparam int CNT_W     = 13;
	localparam int OP_W      = 2;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	// Arithmetic on counts and offsets is carried one bit above the id width.
	localparam int AW        = ID_W + 1;
	localparam int N_W       = $clog2(ID_COUNT + 1);
	localparam int ID_SPACE  = 1 << ID_W;

	// Register reset values.
	localparam int BASE_RESET  = 300;
	localparam int COUNT_RESET = 4096;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_FREE  = 2'd1,
		ST_RANGE    = 2'd2,
		ST_NOT_USED = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ID_BASE  = 1'd0,
		REG_ID_COUNT = 1'd1
	} reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_REL_CHK,
		S_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    clear_map;
		logic    scan_start;
		logic    scan;
		logic    rel_read;
		logic    rel_write;
		logic    alloc_write;
		logic    res_set;
		logic    res_grant;
		status_t res_status;
		logic    push;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic n_zero;
		logic rel_oor;
		logic rel_used;
		logic scan_found;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

FILE: hw/rtl/bia_ctrl.sv
// Controller state machine that sequences allocate, release and clear requests.
module bia_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bia_pkg::sts_t  sts,
	output bia_pkg::cmd_t  cmd
);

	bia_pkg::state_t state_q;
	bia_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bia_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.res_status = bia_pkg::ST_OK;
		in_ready       = 1'b0;
		case (state_q)
			bia_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = bia_pkg::S_DECODE;
				end
			end
			bia_pkg::S_DECODE: begin
				case (sts.op)
					bia_pkg::OP_ALLOC: begin
						if (sts.n_zero) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = bia_pkg::ST_NO_FREE;
							state_d        = bia_pkg::S_RESP;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = bia_pkg::S_SCAN;
						end
					end
					bia_pkg::OP_RELEASE: begin
						if (sts.rel_oor) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = bia_pkg::ST_RANGE;
							state_d        = bia_pkg::S_RESP;
						end else begin
							cmd.rel_read = 1'b1;
							state_d      = bia_pkg::S_REL_CHK;
						end
					end
					bia_pkg::OP_CLEAR: begin
						cmd.clear_map = 1'b1;
						cmd.res_set   = 1'b1;
						state_d       = bia_pkg::S_RESP;
					end
					default: begin
						cmd.res_set = 1'b1;
						state_d     = bia_pkg::S_RESP;
					end
				endcase
			end
			bia_pkg::S_SCAN: begin
				// Reads stream in one word a cycle; stop at the first free bit or the last word.
				cmd.scan = 1'b1;
				if (sts.scan_found) begin
					cmd.alloc_write = 1'b1;
					cmd.res_set     = 1'b1;
					cmd.res_grant   = 1'b1;
					state_d         = bia_pkg::S_RESP;
				end else if (sts.scan_last) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = bia_pkg::ST_NO_FREE;
					state_d        = bia_pkg::S_RESP;
				end
			end
			bia_pkg::S_REL_CHK: begin
				cmd.res_set = 1'b1;
				if (sts.rel_used) begin
					cmd.rel_write = 1'b1;
				end else begin
					cmd.res_status = bia_pkg::ST_NOT_USED;
				end
				state_d = bia_pkg::S_RESP;
			end
			bia_pkg::S_RESP: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = bia_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bia_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/bia_datapath.sv
// Datapath: configuration registers, usage map memory, free-bit search and output register.
module bia_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bia_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bia_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [bia_pkg::OP_W-1:0]      in_op,
	input  logic [bia_pkg::ID_W-1:0]      in_rid,
	input  bia_pkg::cmd_t                 cmd,
	output bia_pkg::sts_t                 sts,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [bia_pkg::ID_W-1:0]      out_granted,
	output logic [bia_pkg::STAT_W-1:0]    out_status
);

	// Index of the single set bit of a one-hot word.
	function automatic logic [bia_pkg::BIT_W-1:0] onehot_index(
		input logic [bia_pkg::WORD_W-1:0] oh
	);
		logic [bia_pkg::BIT_W-1:0] r;
		r = '0;
		for (int b = 0; b < bia_pkg::WORD_W; b++) begin
			if (oh[b]) begin
				r = r | bia_pkg::BIT_W'(b);
			end
		end
		return r;
	endfunction

	logic [bia_pkg::ID_W-1:0]  id_base_q;
	logic [bia_pkg::CNT_W-1:0] id_count_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q  <= bia_pkg::ID_W'(bia_pkg::BASE_RESET);
			id_count_q <= bia_pkg::CNT_W'(bia_pkg::COUNT_RESET);
		end else if (cfg_we) begin
			case (bia_pkg::reg_t'(cfg_index))
				bia_pkg::REG_ID_BASE:  id_base_q  <= cfg_wdata[bia_pkg::ID_W-1:0];
				bia_pkg::REG_ID_COUNT: id_count_q <= cfg_wdata[bia_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Active entry count: limited by the map size and by the room left above the base.
	logic [bia_pkg::AW-1:0] room;
	logic [bia_pkg::AW-1:0] cnt_lim;
	logic [bia_pkg::AW-1:0] cnt_m1;
	logic [bia_pkg::AW-1:0] cnt_word;

	always_comb begin
		room    = bia_pkg::AW'(bia_pkg::ID_SPACE) - {1'b0, id_base_q};
		cnt_lim = bia_pkg::AW'(id_count_q);
		if (cnt_lim > bia_pkg::AW'(bia_pkg::ID_COUNT)) begin
			cnt_lim = bia_pkg::AW'(bia_pkg::ID_COUNT);
		end
		if (cnt_lim > room) begin
			cnt_lim = room;
		end
		cnt_m1   = cnt_lim - bia_pkg::AW'(1);
		cnt_word = cnt_m1 >> bia_pkg::BIT_W;
	end

	bia_pkg::op_t                 op_q;
	logic [bia_pkg::ID_W-1:0]     rid_q;
	logic [bia_pkg::N_W-1:0]      n_q;
	logic [bia_pkg::WADDR_W-1:0]  last_word_q;
	logic [bia_pkg::WORD_W-1:0]   mask_last_q;

	// Request registers, captured when a word is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= bia_pkg::OP_NONE;
		end else if (cmd.load) begin
			op_q <= bia_pkg::op_t'(in_op);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rid_q       <= in_rid;
			n_q         <= bia_pkg::N_W'(cnt_lim);
			last_word_q <= cnt_word[bia_pkg::WADDR_W-1:0];
			mask_last_q <= {bia_pkg::WORD_W{1'b1}} >> (~cnt_m1[bia_pkg::BIT_W-1:0]);
		end
	end

	// Release address and range check.
	logic [bia_pkg::AW-1:0]      rel_off;
	logic [bia_pkg::AW-1:0]      rel_word_full;
	logic [bia_pkg::WADDR_W-1:0] rel_word;
	logic [bia_pkg::BIT_W-1:0]   rel_bit;
	logic                        rel_oor;

	always_comb begin
		rel_off       = {1'b0, rid_q} - {1'b0, id_base_q};
		rel_word_full = rel_off >> bia_pkg::BIT_W;
		rel_word      = rel_word_full[bia_pkg::WADDR_W-1:0];
		rel_bit       = rel_off[bia_pkg::BIT_W-1:0];
		rel_oor       = rel_off[bia_pkg::AW-1] || (rel_off >= bia_pkg::AW'(n_q));
	end

	// Scan read pointer.
	logic [bia_pkg::WADDR_W-1:0] rd_ptr_q;
	logic                        rd_done_q;
	logic                        scan_rd;

	assign scan_rd = cmd.scan && !rd_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			rd_done_q <= 1'b0;
		end else if (cmd.scan_start) begin
			rd_ptr_q  <= '0;
			rd_done_q <= 1'b0;
		end else if (scan_rd) begin
			rd_ptr_q  <= rd_ptr_q + bia_pkg::WADDR_W'(1);
			rd_done_q <= (rd_ptr_q == last_word_q);
		end
	end

	// Usage map memory with one valid bit per row; an invalid row reads as all free.
	logic [bia_pkg::WORD_W-1:0]  map_mem_q [bia_pkg::MAP_WORDS];
	logic [bia_pkg::MAP_WORDS-1:0] row_valid_q;
	logic [bia_pkg::WORD_W-1:0]  rd_data_s1;
	logic                        rd_valid_s1;
	logic                        chk_s1;
	logic [bia_pkg::WADDR_W-1:0] chk_word_s1;
	logic [bia_pkg::WADDR_W-1:0] rd_addr;
	logic                        wr_en;
	logic [bia_pkg::WADDR_W-1:0] wr_addr;
	logic [bia_pkg::WORD_W-1:0]  wr_data;

	assign rd_addr = cmd.rel_read ? rel_word : rd_ptr_q;

	always_ff @(posedge clk) begin
		if (cmd.rel_read || scan_rd) begin
			rd_data_s1  <= map_mem_q[rd_addr];
			rd_valid_s1 <= row_valid_q[rd_addr];
		end
		if (wr_en) begin
			map_mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (cmd.clear_map) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[wr_addr] <= 1'b1;
		end
	end

	// Tracks which scanned word the read data belongs to.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_s1      <= 1'b0;
			chk_word_s1 <= '0;
		end else if (cmd.scan_start) begin
			chk_s1 <= 1'b0;
		end else begin
			chk_s1      <= scan_rd;
			chk_word_s1 <= rd_ptr_q;
		end
	end

	// First free bit of the checked word, limited to active entries.
	logic [bia_pkg::WORD_W-1:0]          word_eff;
	logic [bia_pkg::WORD_W-1:0]          word_mask;
	logic [bia_pkg::WORD_W-1:0]          free_bits;
	logic [bia_pkg::WORD_W-1:0]          low_free;
	logic [bia_pkg::WADDR_W+bia_pkg::BIT_W-1:0] grant_idx;
	logic [bia_pkg::ID_W-1:0]            granted;
	logic [bia_pkg::WORD_W-1:0]          rel_mask;

	always_comb begin
		word_eff  = rd_valid_s1 ? rd_data_s1 : '0;
		word_mask = (chk_word_s1 == last_word_q) ? mask_last_q : {bia_pkg::WORD_W{1'b1}};
		free_bits = ~word_eff & word_mask;
		low_free  = free_bits & (~free_bits + bia_pkg::WORD_W'(1));
		grant_idx = {chk_word_s1, onehot_index(low_free)};
		granted   = id_base_q + bia_pkg::ID_W'(grant_idx);
		rel_mask  = bia_pkg::WORD_W'(1) << rel_bit;
	end

	// Write-back of the updated word.
	always_comb begin
		wr_en   = cmd.alloc_write || cmd.rel_write;
		wr_addr = cmd.alloc_write ? chk_word_s1 : rel_word;
		wr_data = cmd.alloc_write ? (word_eff | low_free) : (word_eff & ~rel_mask);
	end

	// Pending result and output register.
	logic [bia_pkg::ID_W-1:0]   res_granted_q;
	bia_pkg::status_t           res_status_q;
	logic                       out_valid_q;
	logic [bia_pkg::ID_W-1:0]   out_granted_q;
	logic [bia_pkg::STAT_W-1:0] out_status_q;

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_status_q  <= cmd.res_status;
			res_granted_q <= cmd.res_grant ? granted : '0;
		end
		if (cmd.push) begin
			out_granted_q <= res_granted_q;
			out_status_q  <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_granted = out_granted_q;
	assign out_status  = out_status_q;

	// Status toward the controller.
	always_comb begin
		sts.op         = op_q;
		sts.n_zero     = (n_q == '0);
		sts.rel_oor    = rel_oor;
		sts.rel_used   = word_eff[rel_bit];
		sts.scan_found = chk_s1 && (free_bits != '0);
		sts.scan_last  = chk_s1 && (chk_word_s1 == last_word_q);
		sts.out_free   = !out_valid_q || out_ready;
	end

endmodule

FILE: hw/rtl/bitmap_id_allocator.sv
// Allocate scans the map one 64-bit word a cycle through the single memory read port.
// One request is worked on at a time; a new word is taken while the last result waits.
// Reset clears every row valid bit at once, so the whole map reads free, and loads
// id_base = 300 and id_count = 4096.
module bitmap_id_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port.
	input  logic                          cfg_we,
	input  logic [bia_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bia_pkg::CFG_W-1:0]     cfg_wdata,
	// Request stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // [15:0] release_id
	input  logic [1:0]                    s_tuser,   // [1:0] opcode
	// Result stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // [15:0] granted_id
	output logic [1:0]                    m_tuser    // [1:0] status
);

	bia_pkg::cmd_t cmd;
	bia_pkg::sts_t sts;

	bia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bia_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_op       (s_tuser),
		.in_rid      (s_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_granted (m_tdata),
		.out_status  (m_tuser)
	);

endmodule
